FILE: rtl/tbfs_pkg.sv
// Package for the two-bit frame sender with ACK retry.
// Item types, opcodes, event codes and sender phases; no dependencies.
package tbfs_pkg;

  typedef struct packed {
    logic       opcode;
    logic [3:0] channel_in;
    logic [7:0] frame_byte;
    logic       frame_last;
  } tbfs_in_t;

  typedef struct packed {
    logic [3:0] channel_out;
    logic       wants_frame;
    logic       load_accepted;
    logic [1:0] event_res;
  } tbfs_out_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // channel line positions
  localparam int CH_CLK = 3;
  localparam int CH_ACK = 2;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd20;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_WAIT   = 2'd1,
    EV_ACK    = 2'd2,
    EV_RESEND = 2'd3
  } tbfs_event_t;

  typedef enum logic {
    PH_SEND = 1'b0,
    PH_WAIT = 1'b1
  } tbfs_phase_t;

endpackage

FILE: rtl/tbfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/tbfs_core.sv
// Sender state and per-item logic: frame loading, pair serialization, ACK wait.
// Depends on tbfs_pkg; drives the frame store RAM ports.
module tbfs_core #(
  parameter int MAX_FRAME = 256,
  parameter int AW        = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  tbfs_pkg::tbfs_in_t item,
  input  logic [7:0]         ack_timeout,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic [AW-1:0]      rd_addr,
  input  logic [7:0]         rd_data,
  output tbfs_pkg::tbfs_out_t result
);
  import tbfs_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam logic [CW-1:0] MaxLen = CW'(MAX_FRAME);

  logic [CW-1:0] frame_length_r, frame_length_nxt;
  logic [CW-1:0] byte_index_r, byte_index_nxt;
  logic [3:0]    bits_done_r, bits_done_nxt;
  logic [7:0]    shift_byte_r, shift_byte_nxt;
  tbfs_phase_t   phase_r, phase_nxt;
  logic          clock_level_r, clock_level_nxt;
  logic [8:0]    wait_ticks_r, wait_ticks_nxt;
  logic          frame_needed_r, frame_needed_nxt;
  logic          frame_ready_r, frame_ready_nxt;
  logic          fwd_hit_r;
  logic [7:0]    fwd_byte_r;

  logic       is_load, is_tick, store, ack_in, timeout, byte_done, end_frame, send;
  logic [8:0] wait_inc;
  logic [7:0] cur_byte;
  logic [1:0] pos, pair;

  assign is_load   = step && (item.opcode == OP_LOAD);
  assign is_tick   = step && (item.opcode == OP_TICK);
  assign store     = is_load && frame_needed_r && (frame_length_r < MaxLen);
  assign ack_in    = item.channel_in[CH_ACK];
  assign wait_inc  = wait_ticks_r + 9'd1;
  assign timeout   = wait_inc > {1'b0, ack_timeout};
  assign byte_done = bits_done_r[3];
  assign end_frame = byte_done && (byte_index_r >= frame_length_r);
  assign send      = is_tick && (phase_r == PH_SEND) && frame_ready_r && !end_frame;

  // the RAM output always holds the entry at byte_index_r; a write to that
  // entry in the previous cycle is forwarded
  assign cur_byte = byte_done ? (fwd_hit_r ? fwd_byte_r : rd_data) : shift_byte_r;
  assign pos      = byte_done ? 2'd0 : bits_done_r[2:1];

  always_comb begin
    case (pos)
      2'd0:    pair = cur_byte[7:6];
      2'd1:    pair = cur_byte[5:4];
      2'd2:    pair = cur_byte[3:2];
      default: pair = cur_byte[1:0];
    endcase
  end

  assign wr_en   = store;
  assign wr_addr = frame_length_r[AW-1:0];
  assign wr_data = item.frame_byte;
  assign rd_addr = byte_index_nxt[AW-1:0];

  // next state
  always_comb begin
    frame_length_nxt = frame_length_r;
    byte_index_nxt   = byte_index_r;
    bits_done_nxt    = bits_done_r;
    shift_byte_nxt   = shift_byte_r;
    phase_nxt        = phase_r;
    clock_level_nxt  = clock_level_r;
    wait_ticks_nxt   = wait_ticks_r;
    frame_needed_nxt = frame_needed_r;
    frame_ready_nxt  = frame_ready_r;
    if (is_load && frame_needed_r) begin
      if (store) begin
        frame_length_nxt = frame_length_r + CW'(1);
      end
      if (item.frame_last) begin
        frame_needed_nxt = 1'b0;
        frame_ready_nxt  = 1'b1;
      end
    end
    if (is_tick) begin
      unique case (phase_r)
        PH_WAIT: begin
          wait_ticks_nxt = wait_inc;
          if (ack_in) begin
            frame_needed_nxt = 1'b1;
            frame_ready_nxt  = 1'b0;
            byte_index_nxt   = '0;
            frame_length_nxt = '0;
            phase_nxt        = PH_SEND;
            wait_ticks_nxt   = '0;
          end else if (timeout) begin
            frame_ready_nxt = 1'b1;
            byte_index_nxt  = '0;
            phase_nxt       = PH_SEND;
            wait_ticks_nxt  = '0;
          end
        end
        PH_SEND: begin
          if (frame_ready_r) begin
            if (end_frame) begin
              phase_nxt = PH_WAIT;
            end else begin
              if (byte_done) begin
                byte_index_nxt = byte_index_r + CW'(1);
                shift_byte_nxt = cur_byte;
              end
              clock_level_nxt = !clock_level_r;
              bits_done_nxt   = {1'b0, pos, 1'b0} + 4'd2;
            end
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // result fields
  always_comb begin
    result.channel_out   = item.channel_in;
    result.wants_frame   = frame_needed_nxt;
    result.load_accepted = store;
    result.event_res     = EV_NONE;
    if (send) begin
      result.channel_out = {clock_level_nxt, ack_in, pair};
    end
    if (is_tick) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (ack_in) begin
            result.event_res = EV_ACK;
          end else if (timeout) begin
            result.event_res = EV_RESEND;
          end
        end
        PH_SEND: begin
          if (frame_ready_r && end_frame) begin
            result.event_res = EV_WAIT;
          end
        end
        default: result.event_res = EV_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= '0;
      byte_index_r   <= '0;
      bits_done_r    <= 4'd8;
      shift_byte_r   <= '0;
      phase_r        <= PH_SEND;
      clock_level_r  <= 1'b0;
      wait_ticks_r   <= '0;
      frame_needed_r <= 1'b1;
      frame_ready_r  <= 1'b0;
      fwd_hit_r      <= 1'b0;
    end else begin
      frame_length_r <= frame_length_nxt;
      byte_index_r   <= byte_index_nxt;
      bits_done_r    <= bits_done_nxt;
      shift_byte_r   <= shift_byte_nxt;
      phase_r        <= phase_nxt;
      clock_level_r  <= clock_level_nxt;
      wait_ticks_r   <= wait_ticks_nxt;
      frame_needed_r <= frame_needed_nxt;
      frame_ready_r  <= frame_ready_nxt;
      fwd_hit_r      <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_byte_r <= wr_data;
  end

  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(frame_needed_r && frame_ready_r))
    else $error("frame requested and ready at once");

  a_wait_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT) |-> (frame_ready_r && !frame_needed_r))
    else $error("ACK wait without a stored frame");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_length_r <= MaxLen)
    else $error("frame length past store depth");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= frame_length_r)
    else $error("byte index past frame length");

endmodule

FILE: rtl/two_bit_frame_sender_with_ack_retry_unit.sv
// Stop-and-wait sender over a 4-bit channel: accepts one item (load byte or
// channel tick) per clock and returns exactly one result per item, in the cycle
// after acceptance, from an output register. The frame store is a RAM with
// registered read that is always addressed with the next byte index, so the
// byte a tick needs is already at its output; ticks and loads both sustain one
// item per cycle, limited only by the output register being taken. The store
// needs no clearing after reset. ack_timeout is written on the cfg_ channel.
// Depends on tbfs_pkg, tbfs_core and tbfs_ram.
module two_bit_frame_sender_with_ack_retry_unit #(
  parameter int MAX_FRAME = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbfs_pkg::tbfs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tbfs_pkg::tbfs_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import tbfs_pkg::*;

  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  logic          step;
  logic [7:0]    ack_timeout_r;
  logic          out_valid_r;
  tbfs_out_t     out_data_r;
  tbfs_out_t     result;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;

  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tbfs_core #(
    .MAX_FRAME (MAX_FRAME),
    .AW        (AW)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_data),
    .ack_timeout (ack_timeout_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .result      (result)
  );

  tbfs_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        ack_timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !step)
    else $error("transaction accepted over a held result");

  a_tick_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data.opcode == OP_TICK) |-> !wr_en)
    else $error("frame store written on a tick");

endmodule

FILE: tb/two_bit_frame_sender_with_ack_retry_unit_tb.sv
// Testbench for the two-bit frame sender with ACK retry: a directed table, then
// paced random frames, checked against typed table results or a built-in sender predictor.
// Depends on tbfs_pkg and two_bit_frame_sender_with_ack_retry_unit.
`timescale 1ns / 1ps

module two_bit_frame_sender_with_ack_retry_unit_tb;
  import tbfs_pkg::*;

  localparam int FRAME_CAP    = 256;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_FRAME   = FRAME_CAP + 2;
  localparam int CUT_SPAN     = 24;

  typedef struct packed {
    tbfs_in_t  item;
    logic      typed;
    tbfs_out_t result;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  tbfs_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tbfs_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  two_bit_frame_sender_with_ack_retry_unit #(
    .MAX_FRAME(FRAME_CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // shadow copy of the sender state
  logic [7:0]  sh_store [FRAME_CAP];
  logic [8:0]  sh_len     = '0;
  logic [8:0]  sh_idx     = '0;
  logic [3:0]  sh_bits    = 4'd8;
  logic [7:0]  sh_shift   = '0;
  tbfs_phase_t sh_phase   = PH_SEND;
  logic        sh_clk     = 1'b0;
  logic [8:0]  sh_wait    = '0;
  logic        sh_needed  = 1'b1;
  logic        sh_ready   = 1'b0;
  logic [7:0]  sh_timeout = ACK_TIMEOUT_RST;

  tbfs_out_t expected_results [$];
  int fail_count = 0;
  int cycle_count = 0;
  int n_items = 0, n_stored = 0, n_refused = 0;
  int n_waits = 0, n_acks = 0, n_resends = 0;

  // stimulus shaping, kept across phases since a phase may end mid-frame
  int  loads_left = 0;
  int  ack_delay = 0;
  bit  ack_planned = 1'b0;
  int  burst_left = 0;

  // tick rows walk one 3-byte frame through send, ack wait and ack
  dir_row_t dir_rows [23] = '{
    '{'{OP_TICK, 4'hF, 8'h00, 1'b0}, 1'b1, '{4'hF, 1'b1, 1'b0, EV_NONE}},
    '{'{OP_TICK, 4'h0, 8'hFF, 1'b1}, 1'b1, '{4'h0, 1'b1, 1'b0, EV_NONE}},
    '{'{OP_LOAD, 4'hA, 8'hFF, 1'b0}, 1'b1, '{4'hA, 1'b1, 1'b1, EV_NONE}},
    '{'{OP_LOAD, 4'h5, 8'h00, 1'b0}, 1'b1, '{4'h5, 1'b1, 1'b1, EV_NONE}},
    '{'{OP_LOAD, 4'h0, 8'hA5, 1'b1}, 1'b1, '{4'h0, 1'b0, 1'b1, EV_NONE}},
    '{'{OP_LOAD, 4'hF, 8'h3C, 1'b1}, 1'b1, '{4'hF, 1'b0, 1'b0, EV_NONE}},
    '{'{OP_TICK, 4'h0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'hF, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h4, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'hB, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h8, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h3, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h7, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'hC, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'hE, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h2, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'hD, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 4'h3, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD, 4'h6, 8'h77, 1'b1}, 1'b1, '{4'h6, 1'b0, 1'b0, EV_NONE}},
    '{'{OP_TICK, 4'h4, 8'h00, 1'b0}, 1'b1, '{4'h4, 1'b1, 1'b0, EV_ACK}},
    '{'{OP_TICK, 4'h9, 8'h00, 1'b0}, 1'b1, '{4'h9, 1'b1, 1'b0, EV_NONE}}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // appends one expected result to the scoreboard queue
  function automatic void add_expected(tbfs_out_t r);
    expected_results = {expected_results, r};
  endfunction

  // advances the shadow state by one transaction and returns its result
  function automatic tbfs_out_t predict_sender(tbfs_in_t it);
    tbfs_out_t r;
    logic [3:0] pos;
    r.channel_out   = it.channel_in;
    r.wants_frame   = 1'b0;
    r.load_accepted = 1'b0;
    r.event_res     = EV_NONE;
    if (it.opcode == OP_LOAD) begin
      if (sh_needed) begin
        if (sh_len < FRAME_CAP) begin
          sh_store[sh_len[7:0]] = it.frame_byte;
          sh_len = sh_len + 9'd1;
          r.load_accepted = 1'b1;
        end
        if (it.frame_last) begin
          sh_needed = 1'b0;
          sh_ready  = 1'b1;
        end
      end
    end else if (sh_phase == PH_WAIT) begin
      sh_wait = sh_wait + 9'd1;
      if (it.channel_in[CH_ACK]) begin
        sh_needed = 1'b1;
        sh_ready  = 1'b0;
        sh_idx    = '0;
        sh_len    = '0;
        sh_phase  = PH_SEND;
        sh_wait   = '0;
        r.event_res = EV_ACK;
      end else if (sh_wait > {1'b0, sh_timeout}) begin
        sh_ready = 1'b1;
        sh_idx   = '0;
        sh_phase = PH_SEND;
        sh_wait  = '0;
        r.event_res = EV_RESEND;
      end
    end else if (sh_ready) begin
      if (sh_bits >= 4'd8 && sh_idx >= sh_len) begin
        sh_phase = PH_WAIT;
        r.event_res = EV_WAIT;
      end else begin
        if (sh_bits >= 4'd8) begin
          sh_shift = (sh_idx < FRAME_CAP) ? sh_store[sh_idx[7:0]] : 8'h00;
          sh_idx   = sh_idx + 9'd1;
          sh_bits  = '0;
        end
        sh_clk  = ~sh_clk;
        pos     = sh_bits & 4'd6;
        sh_bits = pos + 4'd2;
        r.channel_out = {sh_clk, it.channel_in[CH_ACK], 2'(sh_shift >> (6 - pos))};
      end
    end
    r.wants_frame = sh_needed;
    return r;
  endfunction

  // called just after a falling edge, returns just after the one that follows acceptance
  task automatic send_item(input tbfs_in_t it, input bit typed, input tbfs_out_t typed_res);
    tbfs_out_t predicted;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = predict_sender(it);
    add_expected(typed ? typed_res : predicted);
    n_items++;
    if (it.opcode == OP_LOAD) begin
      if (predicted.load_accepted) n_stored++;
      else n_refused++;
    end
    case (predicted.event_res)
      EV_WAIT:   n_waits++;
      EV_ACK:    n_acks++;
      EV_RESEND: n_resends++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // bursts of back-to-back transactions with gaps between most of them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic write_timeout(input logic [7:0] value);
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sh_timeout = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed frames driven by the shadow state, with some noise
  task automatic stream_frames(input int count, input bit long_frame);
    tbfs_in_t it;
    for (int i = 0; i < count; i++) begin
      pace_sender();
      it.opcode     = OP_TICK;
      it.channel_in = 4'($urandom);
      it.frame_byte = 8'($urandom);
      it.frame_last = 1'($urandom);
      if (sh_needed) begin
        ack_planned = 1'b0;
        if (long_frame) begin
          // stretch whatever is being loaded past the store size
          loads_left = LONG_FRAME;
          long_frame = 1'b0;
        end else if (loads_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            loads_left = $urandom_range(7, 24);
          end else begin
            loads_left = $urandom_range(1, 6);
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          it.opcode = OP_LOAD;
          // occasionally cut an ordinary frame short
          it.frame_last = (loads_left == 1) ||
                          (loads_left <= CUT_SPAN && sh_len < 9'(FRAME_CAP / 2) &&
                           $urandom_range(0, 29) == 0);
          loads_left = it.frame_last ? 0 : loads_left - 1;
        end
      end else if (sh_phase == PH_WAIT) begin
        if (!ack_planned) begin
          ack_planned = 1'b1;
          // a quarter of the waits hold ACK off until the resend; a frame
          // ahead of the long one is acked at once
          if (long_frame) begin
            ack_delay = 0;
          end else begin
            ack_delay = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(0, 8);
          end
        end
        if ($urandom_range(0, 19) == 0) begin
          it.opcode = OP_LOAD;
        end else if (ack_delay == 0) begin
          it.channel_in[CH_ACK] = 1'b1;
        end else begin
          it.channel_in[CH_ACK] = 1'b0;
          ack_delay--;
        end
      end else begin
        ack_planned = 1'b0;
        if ($urandom_range(0, 19) == 0) it.opcode = OP_LOAD;
      end
      send_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int mode, left, tick;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      tick++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= (tick % 4 == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    tbfs_out_t want;
    bit bad;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        bad = 1'b0;
        if (out_data.channel_out !== want.channel_out) begin
          $error("channel_out: expected %h, got %h", want.channel_out, out_data.channel_out);
          bad = 1'b1;
        end
        if (out_data.wants_frame !== want.wants_frame) begin
          $error("wants_frame: expected %b, got %b", want.wants_frame, out_data.wants_frame);
          bad = 1'b1;
        end
        if (out_data.load_accepted !== want.load_accepted) begin
          $error("load_accepted: expected %b, got %b",
                 want.load_accepted, out_data.load_accepted);
          bad = 1'b1;
        end
        if (out_data.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, out_data.event_res);
          bad = 1'b1;
        end
        if (bad) fail_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_bit_frame_sender_with_ack_retry_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset timeout value in force for the table
    for (int i = 0; i < $size(dir_rows); i++) begin
      pace_sender();
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    end
    in_valid <= 1'b0;

    write_timeout(8'd0);
    stream_frames(22, 1'b0);
    write_timeout(8'd255);
    stream_frames(22, 1'b0);
    write_timeout(8'd3);
    stream_frames(22, 1'b0);
    write_timeout(8'($urandom_range(4, 40)));
    stream_frames(22, 1'b0);
    write_timeout(8'd1);
    stream_frames(22, 1'b0);
    // one frame past the store size closes the run; its send is cut off
    write_timeout(ACK_TIMEOUT_RST);
    stream_frames(420, 1'b1);

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions: %0d bytes stored, %0d loads refused",
             n_items, n_stored, n_refused);
    $display("ack waits %0d, acks %0d, timeout resends %0d over six timeout settings",
             n_waits, n_acks, n_resends);
    if (fail_count == 0) begin
      $display("two_bit_frame_sender_with_ack_retry_unit_tb: PASS");
    end else begin
      $display("two_bit_frame_sender_with_ack_retry_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
